// ===== rtl/gdad_pkg.sv =====
// Shared types, constants and calendar helpers for the date advance unit.
// No dependencies; imported by the controller, the datapath and the top level.
package gdad_pkg;

  // Year register width and day counter width
  localparam int unsigned YEAR_BITS     = 16;
  localparam int unsigned COUNT_BITS    = 16;

  // Leap cycle: remainder of the year modulo 400 drives the leap rule
  localparam int unsigned REM_BITS   = 9;
  localparam logic [REM_BITS-1:0] REM_LAST   = 9'd399;
  localparam logic [REM_BITS-1:0] CENTURY_1  = 9'd100;
  localparam logic [REM_BITS-1:0] CENTURY_2  = 9'd200;
  localparam logic [REM_BITS-1:0] CENTURY_3  = 9'd300;

  // Year modulo 400 comes from (year / 16) modulo 25 and the low four year bits;
  // the quotient by 25 uses a reciprocal multiply that is exact over YQ_BITS
  localparam int unsigned YQ_BITS     = YEAR_BITS - 4;
  localparam int unsigned RECIP_SHIFT = YQ_BITS + 5;
  localparam int unsigned RPROD_BITS  = 2 * YQ_BITS + 6;
  localparam logic [4:0]  CYCLE_DIV16 = 5'd25;
  localparam logic [YQ_BITS:0] RECIP_25 = (YQ_BITS + 1)'(
    ((64'd1 << RECIP_SHIFT) + 64'(CYCLE_DIV16) - 64'd1) / 64'(CYCLE_DIV16));

  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [3:0] MONTH_LAST  = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mod_step;
    logic check;
    logic step;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mod_last;
    logic date_ok;
    logic count_zero;
  } dp_sts_t;

  // Leap rule from the year modulo 400
  function automatic logic is_leap(input logic [REM_BITS-1:0] rem);
    logic century;
    century = (rem == CENTURY_1) || (rem == CENTURY_2) || (rem == CENTURY_3);
    return (rem == '0) || ((rem[1:0] == 2'b00) && !century);
  endfunction

  // Month length; codes outside 1 to 12 give zero
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/gdad_dp.sv =====
// Datapath of the date advance unit: date registers, day counter, year-modulo-400
// unit and result formatting. Depends on gdad_pkg.
module gdad_dp import gdad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [7:0]  start_day_i,
  input  logic [7:0]  start_month_i,
  input  logic [15:0] start_year_i,
  input  logic [15:0] days_to_add_i,
  output logic        date_valid_o,
  output logic [4:0]  end_day_o,
  output logic [3:0]  end_month_o,
  output logic [15:0] end_year_o,
  output logic        year_overflow_o
);

  logic [7:0]               day_q, day_d;
  logic [7:0]               month_q, month_d;
  logic [YEAR_BITS-1:0]     year_q, year_d;
  logic [COUNT_BITS-1:0]    count_q, count_d;
  logic [REM_BITS-1:0]      rem_q, rem_d;
  logic [4:0]               quot_lo_q, quot_lo_d;
  logic                     mod_ph_q, mod_ph_d;
  logic                     ovf_q, ovf_d;
  logic                     valid_q, valid_d;

  logic                     leap;
  logic [4:0]               month_len;
  logic                     month_ok;
  logic [YQ_BITS-1:0]       year_hi;
  logic [RPROD_BITS-1:0]    recip_prod;
  logic [4:0]               rem25;
  logic [YEAR_BITS-1:0]     year_inc;

  // Month length of the current date
  assign leap      = is_leap(rem_q);
  assign month_ok  = (month_q >= 8'(MONTH_FIRST)) && (month_q <= 8'(MONTH_LAST));
  assign month_len = month_ok ? days_in(month_q[3:0], leap) : 5'd0;
  assign year_inc  = year_q + YEAR_BITS'(1);

  // Quotient of year / 16 by 25 through a reciprocal multiply; only its low
  // five bits are needed to recover the remainder modulo 25
  assign year_hi    = year_q[YEAR_BITS-1:4];
  assign recip_prod = RPROD_BITS'(year_hi) * RPROD_BITS'(RECIP_25);
  assign rem25      = year_q[8:4] - 5'(quot_lo_q * CYCLE_DIV16);

  assign sts_o.mod_last   = mod_ph_q;
  assign sts_o.date_ok    = month_ok && (year_q != '0) && (day_q != '0)
                            && (day_q <= {3'b000, month_len});
  assign sts_o.count_zero = (count_q == '0);

  // Next state of the date and the counters
  always_comb begin
    day_d     = day_q;
    month_d   = month_q;
    year_d    = year_q;
    count_d   = count_q;
    rem_d     = rem_q;
    quot_lo_d = quot_lo_q;
    mod_ph_d  = mod_ph_q;
    ovf_d     = ovf_q;
    valid_d   = valid_q;
    priority if (cmd_i.load) begin
      day_d    = start_day_i;
      month_d  = start_month_i;
      year_d   = YEAR_BITS'(start_year_i);
      count_d  = COUNT_BITS'(days_to_add_i);
      rem_d    = '0;
      mod_ph_d = 1'b0;
      ovf_d    = 1'b0;
      valid_d  = 1'b0;
    end else if (cmd_i.mod_step) begin
      // First beat holds the quotient, second folds it into the remainder
      if (!mod_ph_q) begin
        quot_lo_d = recip_prod[RECIP_SHIFT +: 5];
        mod_ph_d  = 1'b1;
      end else begin
        rem_d = {rem25, year_q[3:0]};
      end
    end else if (cmd_i.check) begin
      valid_d = sts_o.date_ok;
    end else if (cmd_i.step) begin
      count_d = count_q - COUNT_BITS'(1);
      if (day_q >= {3'b000, month_len}) begin
        day_d = 8'd1;
        if (month_q < 8'(MONTH_LAST)) begin
          month_d = month_q + 8'd1;
        end else begin
          month_d = 8'(MONTH_FIRST);
          year_d  = year_inc;
          // Wrap drops the year to zero, which starts a fresh leap cycle
          if (year_inc == '0) begin
            ovf_d = 1'b1;
            rem_d = '0;
          end else begin
            rem_d = (rem_q == REM_LAST) ? '0 : rem_q + REM_BITS'(1);
          end
        end
      end else begin
        day_d = day_q + 8'd1;
      end
    end
  end

  // Control flags, day counter and year remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      ovf_q    <= 1'b0;
      mod_ph_q <= 1'b0;
      count_q  <= '0;
      rem_q    <= '0;
    end else begin
      valid_q  <= valid_d;
      ovf_q    <= ovf_d;
      mod_ph_q <= mod_ph_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
    end
  end

  // Date payload and the held quotient
  always_ff @(posedge clk_i) begin
    day_q     <= day_d;
    month_q   <= month_d;
    year_q    <= year_d;
    quot_lo_q <= quot_lo_d;
  end

  // Zero every field of an invalid date
  assign date_valid_o    = valid_q;
  assign end_day_o       = valid_q ? day_q[4:0] : 5'd0;
  assign end_month_o     = valid_q ? month_q[3:0] : 4'd0;
  assign end_year_o      = valid_q ? 16'(year_q) : 16'd0;
  assign year_overflow_o = valid_q & ovf_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= REM_LAST)
    else $error("year remainder out of range");

  a_step_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (day_q != '0) && (month_q >= 8'(MONTH_FIRST))
                   && (month_q <= 8'(MONTH_LAST)))
    else $error("date left calendar range after a step");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> count_q == $past(count_q) - COUNT_BITS'(1))
    else $error("day counter did not advance by one");

endmodule

// ===== rtl/gdad_ctrl.sv =====
// Controller of the date advance unit: sequences load, remainder, check and
// day steps, and drives the handshake. Depends on gdad_pkg.
module gdad_ctrl import gdad_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    done_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the sequence and issue datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.date_ok ? ST_STEP : ST_DONE;
      end
      ST_STEP: begin
        if (sts_i.count_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> state_q == ST_IDLE)
    else $error("result strobe held longer than one beat");

  a_step_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !sts_i.count_zero)
    else $error("day step issued with counter at zero");

  a_mod_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) && sts_i.mod_last |=> state_q == ST_CHECK)
    else $error("remainder phase did not hand over to the check");

endmodule

// ===== rtl/gregorian_date_add_days_unit.sv =====
// Top level of the Gregorian date advance unit: joins controller and datapath.
// Depends on gdad_pkg, gdad_ctrl and gdad_dp.
// Sequence: load, year remainder, date check, then day steps until the counter
//   reaches zero for a valid date (none for an invalid one), then the done_o beat.
// One item at a time: a new start is taken only once the unit is back in idle
//   after the result beat.
// busy is high from acceptance through the result beat; the receiver cannot stall.
// Reset: rst_ni clears the sequencer to idle, asynchronously.
module gregorian_date_add_days_unit import gdad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  start_day_i,
  input  logic [7:0]  start_month_i,
  input  logic [15:0] start_year_i,
  input  logic [15:0] days_to_add_i,
  output logic        done_o,
  output logic        date_valid_o,
  output logic [4:0]  end_day_o,
  output logic [3:0]  end_month_o,
  output logic [15:0] end_year_o,
  output logic        year_overflow_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the work
  gdad_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // Hold and advance the date
  gdad_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_day_i     (start_day_i),
    .start_month_i   (start_month_i),
    .start_year_i    (start_year_i),
    .days_to_add_i   (days_to_add_i),
    .date_valid_o    (date_valid_o),
    .end_day_o       (end_day_o),
    .end_month_o     (end_month_o),
    .end_year_o      (end_year_o),
    .year_overflow_o (year_overflow_o)
  );

endmodule

// ===== bench/gregorian_date_add_days_unit_tb.sv =====
// Self-checking bench for the Gregorian date advance unit: start/busy command beats in,
// done_o result beats out, each checked against a calendar predictor held in a scoreboard.
// Depends on gdad_pkg and gregorian_date_add_days_unit.
module gregorian_date_add_days_unit_tb import gdad_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One result beat as the unit should present it
  typedef struct packed {
    logic        valid;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        ovf;
  } end_date_t;

  // Calendar predictor plus the store of dates still owed by the unit
  class date_checker;
    end_date_t   expected_dates[$];
    int unsigned mismatches;

    static function bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int unsigned month_length(int unsigned m, int unsigned y);
      if (m < 32'(MONTH_FIRST) || m > 32'(MONTH_LAST)) return 0;
      if (m == 32'(MONTH_FEB)) return leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    // Month length is zero for a bad month, so that case falls out here too
    static function bit date_ok(int unsigned d, int unsigned m, int unsigned y);
      return (y != 0) && (d >= 1) && (d <= month_length(m, y));
    endfunction

    // Walk the date forward one day at a time, wrapping the year at 16 bits
    function end_date_t advance_date(int unsigned d, int unsigned m, int unsigned y,
                                     int unsigned n);
      end_date_t   r;
      int unsigned i;
      r = '0;
      if (!date_ok(d, m, y)) return r;
      for (i = 0; i < n; i++) begin
        d++;
        if (d > month_length(m, y)) begin
          d = 1;
          if (m < 32'(MONTH_LAST)) begin
            m++;
          end else begin
            m = 32'(MONTH_FIRST);
            y = (y + 1) & 32'h0000_FFFF;
            if (y == 0) r.ovf = 1'b1;
          end
        end
      end
      r.valid = 1'b1;
      r.day   = d[4:0];
      r.month = m[3:0];
      r.year  = y[15:0];
      return r;
    endfunction

    function void note_item(logic [7:0] d, logic [7:0] m, logic [15:0] y, logic [15:0] n);
      expected_dates.push_back(advance_date(32'(d), 32'(m), 32'(y), 32'(n)));
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one result beat against the oldest owed date
    task check_result(logic v, logic [4:0] d, logic [3:0] m, logic [15:0] y, logic o);
      end_date_t want;
      if (expected_dates.size() == 0) begin
        report("result beat with no date owed");
        return;
      end
      want = expected_dates.pop_front();
      if (v !== want.valid)
        report($sformatf("date_valid got %b want %b", v, want.valid));
      if (d !== want.day)
        report($sformatf("end_day got %0d want %0d", d, want.day));
      if (m !== want.month)
        report($sformatf("end_month got %0d want %0d", m, want.month));
      if (y !== want.year)
        report($sformatf("end_year got %0d want %0d", y, want.year));
      if (o !== want.ovf)
        report($sformatf("year_overflow got %b want %b", o, want.ovf));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [7:0]  start_day_i;
  logic [7:0]  start_month_i;
  logic [15:0] start_year_i;
  logic [15:0] days_to_add_i;
  logic        done_o;
  logic        date_valid_o;
  logic [4:0]  end_day_o;
  logic [3:0]  end_month_o;
  logic [15:0] end_year_o;
  logic        year_overflow_o;

  date_checker chk;

  gregorian_date_add_days_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .start_day_i     (start_day_i),
    .start_month_i   (start_month_i),
    .start_year_i    (start_year_i),
    .days_to_add_i   (days_to_add_i),
    .done_o          (done_o),
    .date_valid_o    (date_valid_o),
    .end_day_o       (end_day_o),
    .end_month_o     (end_month_o),
    .end_year_o      (end_year_o),
    .year_overflow_o (year_overflow_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Check every result beat at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1)
      chk.check_result(date_valid_o, end_day_o, end_month_o, end_year_o, year_overflow_o);
  end

  // Idle the sender in bursts, or not at all
  function automatic int unsigned pick_gap(bit idle_on);
    if (!idle_on) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0;
  endfunction

  // Present one command beat and hold it until the unit takes it
  task automatic send_date(input logic [7:0] d, input logic [7:0] m, input logic [15:0] y,
                           input logic [15:0] n, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    start_day_i   <= d;
    start_month_i <= m;
    start_year_i  <= y;
    days_to_add_i <= n;
    do @(posedge clk_i); while (busy);
    chk.note_item(d, m, y, n);
  endtask

  // Mostly well-formed dates with random content, the rest broken dates and noise
  task automatic send_random(input int unsigned idx, input bit idle_on);
    int unsigned d, m, y, n, len;
    if ($urandom_range(0, 9) < 7) begin
      m = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       y = $urandom_range(1, 65535);
        1:       y = $urandom_range(65400, 65535);
        2:       y = 100 * $urandom_range(1, 655);
        default: y = $urandom_range(1, 3000);
      endcase
      len = date_checker::month_length(m, y);
      d = ($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len);
      if (idx % 20 == 19)
        n = $urandom_range(32768, 65535);
      else if ($urandom_range(0, 3) == 0)
        n = $urandom_range(0, 3);
      else
        n = $urandom_range(0, 1200);
    end else begin
      m = $urandom_range(1, 12);
      y = $urandom_range(1, 65535);
      case ($urandom_range(0, 3))
        0: begin
          d = $urandom_range(0, 255);
          m = $urandom_range(0, 255);
          y = $urandom_range(0, 65535);
        end
        1: begin
          y = 0;
          d = $urandom_range(1, 28);
        end
        2: d = date_checker::month_length(m, y) + 1;
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            d = 0;
          end else begin
            m = 32'(MONTH_FEB);
            d = 29;
            y = $urandom_range(0, 16383) * 4 + 1;
          end
        end
      endcase
      // Keep an accidental valid date short
      n = date_checker::date_ok(d, m, y) ? $urandom_range(0, 1200) : $urandom_range(0, 65535);
    end
    send_date(8'(d), 8'(m), 16'(y), 16'(n), pick_gap(idle_on));
  endtask

  initial begin
    int unsigned k;
    bit          idle_on;
    chk = new();
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    start_day_i   <= '0;
    start_month_i <= '0;
    start_year_i  <= '0;
    days_to_add_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, leap rules, carries, wrap and invalid dates
    send_date(8'd1,   8'd1,   16'd1,     16'd0,     pick_gap(1'b1));
    send_date(8'd31,  8'd12,  16'd65535, 16'd1,     pick_gap(1'b1));
    send_date(8'd28,  8'd2,   16'd1900,  16'd1,     pick_gap(1'b1));
    send_date(8'd28,  8'd2,   16'd2000,  16'd1,     pick_gap(1'b1));
    send_date(8'd29,  8'd2,   16'd2000,  16'd0,     pick_gap(1'b1));
    send_date(8'd29,  8'd2,   16'd1900,  16'd5,     pick_gap(1'b1));
    send_date(8'd29,  8'd2,   16'd2024,  16'd365,   pick_gap(1'b1));
    send_date(8'd0,   8'd5,   16'd2020,  16'd10,    pick_gap(1'b1));
    send_date(8'd10,  8'd0,   16'd2020,  16'd10,    pick_gap(1'b1));
    send_date(8'd10,  8'd13,  16'd2020,  16'd10,    pick_gap(1'b1));
    send_date(8'd255, 8'd255, 16'd65535, 16'd65535, pick_gap(1'b1));
    send_date(8'd1,   8'd1,   16'd0,     16'd1,     pick_gap(1'b1));
    send_date(8'd32,  8'd1,   16'd2020,  16'd1,     pick_gap(1'b1));
    send_date(8'd31,  8'd4,   16'd2020,  16'd1,     pick_gap(1'b1));
    send_date(8'd30,  8'd4,   16'd2023,  16'd1,     pick_gap(1'b1));
    send_date(8'd31,  8'd1,   16'd2023,  16'd30,    pick_gap(1'b1));
    send_date(8'd31,  8'd12,  16'd65534, 16'd366,   pick_gap(1'b1));
    send_date(8'd1,   8'd1,   16'd1,     16'd65535, pick_gap(1'b1));
    send_date(8'd31,  8'd12,  16'd65535, 16'd65535, pick_gap(1'b1));
    send_date(8'd31,  8'd12,  16'd65535, 16'd60,    pick_gap(1'b1));

    // Random: idle bursts come and go, none in the last stretch
    for (k = 0; k < 100; k++) begin
      idle_on = (k < 80) && ((k / 10) % 3 != 2);
      send_random(k, idle_on);
    end
    start <= 1'b0;

    // Drain, then watch a while for stray beats
    while (chk.expected_dates.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (chk.mismatches == 0) begin
      $display("PASS gregorian_date_add_days_unit");
    end else begin
      $display("FAIL gregorian_date_add_days_unit");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(800_000_000);
    $display("FAIL gregorian_date_add_days_unit");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gdad_pkg.sv
rtl/gdad_dp.sv
rtl/gdad_ctrl.sv
rtl/gregorian_date_add_days_unit.sv
bench/gregorian_date_add_days_unit_tb.sv
